// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W  = 13;
    localparam int CHAN_W = 8;

    // hue scale in 1/16 degree units
    localparam int HUE_FULL   = 5760;
    localparam int HUE_SECTOR = 960;
    localparam int REM_W      = 10;

    // fixed-point scales
    localparam int FRAC_ONE  = 255;
    localparam int FRAC_FULL = FRAC_ONE * HUE_SECTOR;
    localparam int PNUM_W    = 2 * CHAN_W;
    localparam int QNUM_W    = 18;
    localparam int PROD_W    = CHAN_W + QNUM_W;

    // reciprocal of FRAC_FULL for the constant divider
    localparam int     DIV_SHIFT = 34;
    localparam longint DIV_RECIP = (longint'(1) << DIV_SHIFT) / FRAC_FULL;
    localparam int     RECIP_W   = 17;
    localparam int     DPROD_W   = PROD_W + RECIP_W;

    // pipeline depth, input register to output register
    localparam int PIPE_DEPTH = 6;

    // 60 degree hue sectors
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW     = 3'd0,
        SECTOR_YELLOW_GREEN   = 3'd1,
        SECTOR_GREEN_CYAN     = 3'd2,
        SECTOR_CYAN_BLUE      = 3'd3,
        SECTOR_BLUE_MAGENTA   = 3'd4,
        SECTOR_MAGENTA_RED    = 3'd5
    } hsv_sector_t;

    // load enables of the two divider stages
    typedef struct packed {
        logic est;
        logic fix;
    } div_en_t;

endpackage : hsv2rgb_pkg
`default_nettype wire

// ===== rtl/hsv2rgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Valid/ready stream interfaces for HSV input pixels and RGB output pixels.
// ----------------------------------------------------------------------------
interface hsv_pixel_if
    import hsv2rgb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HUE_W-1:0]    hue;
    logic [CHAN_W-1:0]   saturation;
    logic [CHAN_W-1:0]   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface : hsv_pixel_if

interface rgb_pixel_if
    import hsv2rgb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface : rgb_pixel_if
`default_nettype wire

// ===== rtl/hsv2rgb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_div
// Two-stage divide by FRAC_FULL: reciprocal estimate, then one correction.
// ----------------------------------------------------------------------------
module hsv2rgb_div
    import hsv2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire div_en_t           en,
    input  wire logic [PROD_W-1:0] dividend,
    output logic [CHAN_W-1:0]      quotient
);

    logic [DPROD_W-1:0] recip_prod;
    logic [CHAN_W-1:0]  est_next;
    logic [CHAN_W-1:0]  est_reg;
    logic [PROD_W-1:0]  dvd_reg;
    logic [PROD_W-1:0]  est_back;
    logic [PROD_W-1:0]  remainder;
    logic [CHAN_W-1:0]  quot_next;
    logic [CHAN_W-1:0]  quot_reg;

    // estimate is exact or one low
    always_comb
    begin
        recip_prod = DPROD_W'(dividend) * DPROD_W'(DIV_RECIP);
        est_next   = recip_prod[DIV_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.est)
        begin
            est_reg <= est_next;
            dvd_reg <= dividend;
        end
    end

    // remainder check and correction
    always_comb
    begin
        est_back  = PROD_W'(est_reg) * PROD_W'(FRAC_FULL);
        remainder = dvd_reg - est_back;
        if (remainder >= PROD_W'(FRAC_FULL))
            quot_next = est_reg + CHAN_W'(1);
        else
            quot_next = est_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.fix)
            quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule : hsv2rgb_div
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Pipelined HSV to RGB pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   hsv carries one request per pixel: hue (1/16 degree), saturation and
//   brightness. rgb returns one request per pixel with red, green, blue,
//   in input order.
//   Six register stages: sector split, p/q/t numerators, brightness
//   products and divide by 255, reciprocal estimate, correction, channel
//   select. rgb.valid rises once the pixel reaches the output register, and
//   the result is taken on an edge where rgb.ready is high. Throughput is
//   one pixel per cycle while rgb.ready is high; each stage holds its own
//   valid bit, so a pixel enters when the stage behind it moves or is empty.
//   When the receiver stalls, the output register holds its result and
//   the stages fill up behind it; hsv.ready drops only when all are full.
//   Nothing is lost or repeated across a stall.
//   Reset (rst_n low) clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hsv_pixel_if.sink   hsv,
    rgb_pixel_if.source rgb
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] en;
    div_en_t               div_en;

    // stage enables, back to front
    always_comb
    begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || rgb.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
        div_en.est = en[3];
        div_en.fix = en[4];
    end

    assign hsv.ready = en[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= hsv.valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: hue out of range mapped to 0, and sector split
    logic [HUE_W-1:0]  hue_clamp;
    logic [HUE_W-1:0]  sector_base;
    hsv_sector_t       sector_next;
    logic [HUE_W-1:0]  rem_wide;
    hsv_sector_t       sector_s1_reg;
    logic [REM_W-1:0]  rem_s1_reg;
    logic [CHAN_W-1:0] sat_s1_reg;
    logic [CHAN_W-1:0] val_s1_reg;

    always_comb
    begin
        hue_clamp = (hsv.hue >= HUE_W'(HUE_FULL)) ? '0 : hsv.hue;
        priority if (hue_clamp < HUE_W'(HUE_SECTOR))
        begin
            sector_next = SECTOR_RED_YELLOW;
            sector_base = '0;
        end
        else if (hue_clamp < HUE_W'(2 * HUE_SECTOR))
        begin
            sector_next = SECTOR_YELLOW_GREEN;
            sector_base = HUE_W'(HUE_SECTOR);
        end
        else if (hue_clamp < HUE_W'(3 * HUE_SECTOR))
        begin
            sector_next = SECTOR_GREEN_CYAN;
            sector_base = HUE_W'(2 * HUE_SECTOR);
        end
        else if (hue_clamp < HUE_W'(4 * HUE_SECTOR))
        begin
            sector_next = SECTOR_CYAN_BLUE;
            sector_base = HUE_W'(3 * HUE_SECTOR);
        end
        else if (hue_clamp < HUE_W'(5 * HUE_SECTOR))
        begin
            sector_next = SECTOR_BLUE_MAGENTA;
            sector_base = HUE_W'(4 * HUE_SECTOR);
        end
        else
        begin
            sector_next = SECTOR_MAGENTA_RED;
            sector_base = HUE_W'(5 * HUE_SECTOR);
        end
        rem_wide = hue_clamp - sector_base;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sector_s1_reg <= sector_next;
            rem_s1_reg    <= rem_wide[REM_W-1:0];
            sat_s1_reg    <= hsv.saturation;
            val_s1_reg    <= hsv.brightness;
        end
    end

    // stage 2: numerators of p, q and t
    logic [CHAN_W-1:0] sat_inv;
    logic [REM_W-1:0]  rem_inv;
    logic [QNUM_W-1:0] q_sub;
    logic [QNUM_W-1:0] t_sub;
    logic [PNUM_W-1:0] p_num_s2_reg;
    logic [QNUM_W-1:0] q_num_s2_reg;
    logic [QNUM_W-1:0] t_num_s2_reg;
    hsv_sector_t       sector_s2_reg;
    logic [CHAN_W-1:0] val_s2_reg;

    always_comb
    begin
        sat_inv = CHAN_W'(FRAC_ONE) - sat_s1_reg;
        rem_inv = REM_W'(HUE_SECTOR) - rem_s1_reg;
        q_sub   = QNUM_W'(sat_s1_reg) * QNUM_W'(rem_s1_reg);
        t_sub   = QNUM_W'(sat_s1_reg) * QNUM_W'(rem_inv);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_num_s2_reg  <= PNUM_W'(val_s1_reg) * PNUM_W'(sat_inv);
            q_num_s2_reg  <= QNUM_W'(FRAC_FULL) - q_sub;
            t_num_s2_reg  <= QNUM_W'(FRAC_FULL) - t_sub;
            sector_s2_reg <= sector_s1_reg;
            val_s2_reg    <= val_s1_reg;
        end
    end

    // stage 3: brightness products, p divided by 255
    logic [PNUM_W-1:0] p_adj;
    logic [PROD_W-1:0] q_prod_s3_reg;
    logic [PROD_W-1:0] t_prod_s3_reg;
    logic [CHAN_W-1:0] p_s3_reg;
    hsv_sector_t       sector_s3_reg;
    logic [CHAN_W-1:0] val_s3_reg;

    // floor(x / 255) = (x + 1 + x / 256) / 256 for x below 65280
    assign p_adj = p_num_s2_reg + PNUM_W'(1) + (p_num_s2_reg >> CHAN_W);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q_prod_s3_reg <= PROD_W'(val_s2_reg) * PROD_W'(q_num_s2_reg);
            t_prod_s3_reg <= PROD_W'(val_s2_reg) * PROD_W'(t_num_s2_reg);
            p_s3_reg      <= p_adj[PNUM_W-1:CHAN_W];
            sector_s3_reg <= sector_s2_reg;
            val_s3_reg    <= val_s2_reg;
        end
    end

    // stages 4 and 5: q and t divided by 255 * 960
    logic [CHAN_W-1:0] q_s5;
    logic [CHAN_W-1:0] t_s5;
    logic [CHAN_W-1:0] p_s4_reg;
    logic [CHAN_W-1:0] p_s5_reg;
    hsv_sector_t       sector_s4_reg;
    hsv_sector_t       sector_s5_reg;
    logic [CHAN_W-1:0] val_s4_reg;
    logic [CHAN_W-1:0] val_s5_reg;

    hsv2rgb_div u_div_q (
        .clk      (clk),
        .en       (div_en),
        .dividend (q_prod_s3_reg),
        .quotient (q_s5)
    );

    hsv2rgb_div u_div_t (
        .clk      (clk),
        .en       (div_en),
        .dividend (t_prod_s3_reg),
        .quotient (t_s5)
    );

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            p_s4_reg      <= p_s3_reg;
            sector_s4_reg <= sector_s3_reg;
            val_s4_reg    <= val_s3_reg;
        end
        if (en[4])
        begin
            p_s5_reg      <= p_s4_reg;
            sector_s5_reg <= sector_s4_reg;
            val_s5_reg    <= val_s4_reg;
        end
    end

    // stage 6: channel select by sector
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    always_comb
    begin
        unique case (sector_s5_reg)
            SECTOR_RED_YELLOW:
            begin
                red_next = val_s5_reg; green_next = t_s5; blue_next = p_s5_reg;
            end
            SECTOR_YELLOW_GREEN:
            begin
                red_next = q_s5; green_next = val_s5_reg; blue_next = p_s5_reg;
            end
            SECTOR_GREEN_CYAN:
            begin
                red_next = p_s5_reg; green_next = val_s5_reg; blue_next = t_s5;
            end
            SECTOR_CYAN_BLUE:
            begin
                red_next = p_s5_reg; green_next = q_s5; blue_next = val_s5_reg;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                red_next = t_s5; green_next = p_s5_reg; blue_next = val_s5_reg;
            end
            SECTOR_MAGENTA_RED:
            begin
                red_next = val_s5_reg; green_next = p_s5_reg; blue_next = q_s5;
            end
            default:
            begin
                red_next = val_s5_reg; green_next = p_s5_reg; blue_next = q_s5;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = valid_reg[PIPE_DEPTH-1];
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule : hsv_to_rgb_converter_core
`default_nettype wire
